@@ sv/ctlf_pkg.sv @@
// ctlf_pkg: phase and event codes, field widths and tdata bit positions
// for the capture job lifecycle controller. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctlf_pkg;

    localparam int MASK_BITS  = 32;   // used low bits of the target mask, 1..32
    localparam int ERROR_BITS = 8;    // used low bits of the error code, 1..8

    localparam int TARGET_W = 32;
    localparam int TIME_W   = 64;
    localparam int PHASE_W  = 4;
    localparam int ERR_W    = 8;
    localparam int KIND_W   = 2;

    localparam logic [TARGET_W-1:0] TARGET_KEEP =
        (MASK_BITS >= TARGET_W) ? {TARGET_W{1'b1}}
                                : TARGET_W'((64'd1 << MASK_BITS) - 64'd1);
    localparam logic [ERR_W-1:0] ERROR_KEEP =
        (ERROR_BITS >= ERR_W) ? {ERR_W{1'b1}}
                              : ERR_W'((32'd1 << ERROR_BITS) - 32'd1);

    // input word layout
    localparam int IN_ID_LSB   = 0;
    localparam int IN_MASK_LSB = IN_ID_LSB + 1;
    localparam int IN_DL_LSB   = IN_MASK_LSB + TARGET_W;
    localparam int IN_EXP_LSB  = IN_DL_LSB + TIME_W;
    localparam int IN_NXT_LSB  = IN_EXP_LSB + PHASE_W;
    localparam int IN_EP_LSB   = IN_NXT_LSB + PHASE_W;
    localparam int IN_ERR_LSB  = IN_EP_LSB + TIME_W;
    localparam int IN_USED_W   = IN_ERR_LSB + ERR_W;
    localparam int IN_W        = ((IN_USED_W + 7) / 8) * 8;

    // output word layout
    localparam int OUT_ST_LSB   = 0;
    localparam int OUT_PH_LSB   = OUT_ST_LSB + 1;
    localparam int OUT_BUSY_LSB = OUT_PH_LSB + PHASE_W;
    localparam int OUT_EP_LSB   = OUT_BUSY_LSB + 1;
    localparam int OUT_E1_LSB   = OUT_EP_LSB + TIME_W;
    localparam int OUT_E2_LSB   = OUT_E1_LSB + ERR_W;
    localparam int OUT_USED_W   = OUT_E2_LSB + ERR_W;
    localparam int OUT_W        = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE       = 4'd0,
        PH_PREPARING  = 4'd1,
        PH_READY      = 4'd2,
        PH_STARTING   = 4'd3,
        PH_RUNNING    = 4'd4,
        PH_STOPPING   = 4'd5,
        PH_COMMITTING = 4'd6,
        PH_DONE       = 4'd7,
        PH_FAILED     = 4'd8
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_BEGIN = 2'd0,
        EV_MOVE  = 2'd1,
        EV_STOP  = 2'd2,
        EV_FAIL  = 2'd3
    } kind_t;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    function automatic logic phase_active(input logic [PHASE_W-1:0] p);
        return (p >= PH_PREPARING) && (p <= PH_COMMITTING);
    endfunction

    // fixed table of legal checked moves
    function automatic logic legal_move(input logic [PHASE_W-1:0] from,
                                        input logic [PHASE_W-1:0] to);
        logic ok;
        ok = 1'b0;
        if (to == PH_FAILED)
        begin
            ok = phase_active(from);
        end
        else
        begin
            case (from)
                PH_PREPARING:  ok = (to == PH_READY) || (to == PH_STOPPING);
                PH_READY:      ok = (to == PH_STARTING) || (to == PH_STOPPING);
                PH_STARTING:   ok = (to == PH_RUNNING) || (to == PH_STOPPING);
                PH_RUNNING:    ok = (to == PH_STOPPING);
                PH_STOPPING:   ok = (to == PH_COMMITTING);
                PH_COMMITTING: ok = (to == PH_DONE);
                default:       ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ sv/capture_task_lifecycle_fsm_unit.sv @@
// capture_task_lifecycle_fsm_unit: job phase tracker, one result word per event word.
// depends on ctlf_pkg.
//
//  channel   dir  tdata                                            tuser
//  s_axis    in   id_present,targets,deadline,expected_phase,      kind
//                 next_phase,epoch,error_code (184 b)
//  m_axis    out  status,phase,busy_res,stop_epoch_out,            -
//                 first_error,second_error (88 b)
//
//  an event word is registered on entry, evaluated against the job state and its
//  result registered; one word per cycle while m_axis_tready stays high.
//  the evaluation stage advances whenever the result register is empty or drained,
//  so a word can enter while an earlier result still waits on m_axis_tready.
//  reset returns the job to idle with no epoch and no errors recorded.
`timescale 1ns / 1ps
`default_nettype none

module capture_task_lifecycle_fsm_unit (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    // id_present, targets, deadline, expected_phase, next_phase, epoch, error_code
    input  wire  [ctlf_pkg::IN_W-1:0] s_axis_tdata,
    // kind
    input  wire  [ctlf_pkg::KIND_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    // status, phase, busy_res, stop_epoch_out, first_error, second_error
    output logic [ctlf_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int TW = ctlf_pkg::TIME_W;
    localparam int PW = ctlf_pkg::PHASE_W;
    localparam int EW = ctlf_pkg::ERR_W;

    // input stage
    logic                         in_valid_reg;
    logic [ctlf_pkg::IN_W-1:0]    in_data_reg;
    ctlf_pkg::kind_t              in_kind_reg;

    // job state
    ctlf_pkg::phase_t             phase_reg, phase_next;
    logic [TW-1:0]                epoch_reg, epoch_next;
    logic [EW-1:0]                err1_reg, err1_next;
    logic [EW-1:0]                err2_reg, err2_next;
    logic                         ok_next;

    // result stage
    logic                         out_valid_reg;
    logic [ctlf_pkg::OUT_W-1:0]   out_data_reg, out_data_next;

    logic                         adv;

    logic                         f_id;
    logic [ctlf_pkg::TARGET_W-1:0] f_mask;
    logic [PW-1:0]                f_exp;
    logic [PW-1:0]                f_nxt;
    logic [TW-1:0]                f_epoch;
    logic [EW-1:0]                f_err;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign f_id    = in_data_reg[ctlf_pkg::IN_ID_LSB];
    assign f_mask  = in_data_reg[ctlf_pkg::IN_MASK_LSB +: ctlf_pkg::TARGET_W]
                     & ctlf_pkg::TARGET_KEEP;
    assign f_exp   = in_data_reg[ctlf_pkg::IN_EXP_LSB +: PW];
    assign f_nxt   = in_data_reg[ctlf_pkg::IN_NXT_LSB +: PW];
    assign f_epoch = in_data_reg[ctlf_pkg::IN_EP_LSB +: TW];
    assign f_err   = in_data_reg[ctlf_pkg::IN_ERR_LSB +: EW] & ctlf_pkg::ERROR_KEEP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_kind_reg <= ctlf_pkg::kind_t'(s_axis_tuser);
        end
    end

    // next state of the job
    always_comb
    begin
        phase_next = phase_reg;
        epoch_next = epoch_reg;
        err1_next  = err1_reg;
        err2_next  = err2_reg;
        ok_next    = 1'b0;
        unique case (in_kind_reg)
            ctlf_pkg::EV_BEGIN:
            begin
                if (f_id && (f_mask != '0) &&
                    (phase_reg == ctlf_pkg::PH_IDLE || phase_reg == ctlf_pkg::PH_DONE ||
                     phase_reg == ctlf_pkg::PH_FAILED))
                begin
                    phase_next = ctlf_pkg::PH_PREPARING;
                    epoch_next = '0;
                    err1_next  = '0;
                    err2_next  = '0;
                    ok_next    = 1'b1;
                end
            end
            ctlf_pkg::EV_MOVE:
            begin
                if ((f_exp == phase_reg) && ctlf_pkg::legal_move(phase_reg, f_nxt))
                begin
                    phase_next = ctlf_pkg::phase_t'(f_nxt);
                    ok_next    = 1'b1;
                end
            end
            ctlf_pkg::EV_STOP:
            begin
                if (f_epoch != '0)
                begin
                    if (phase_reg >= ctlf_pkg::PH_STOPPING)
                    begin
                        // repeated stop: first epoch sticks, same epoch accepted again
                        if (epoch_reg == '0)
                        begin
                            epoch_next = f_epoch;
                            ok_next    = 1'b1;
                        end
                        else
                        begin
                            ok_next = (epoch_reg == f_epoch);
                        end
                    end
                    else if (phase_reg != ctlf_pkg::PH_IDLE)
                    begin
                        phase_next = ctlf_pkg::PH_STOPPING;
                        epoch_next = f_epoch;
                        ok_next    = 1'b1;
                    end
                end
            end
            ctlf_pkg::EV_FAIL:
            begin
                if (f_err != '0)
                begin
                    if (err1_reg == '0)
                    begin
                        err1_next = f_err;
                    end
                    else if (err2_reg == '0)
                    begin
                        err2_next = f_err;
                    end
                    if (ctlf_pkg::phase_active(phase_reg))
                    begin
                        phase_next = ctlf_pkg::PH_FAILED;
                    end
                    ok_next = 1'b1;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // result word
    always_comb
    begin
        out_data_next = '0;
        out_data_next[ctlf_pkg::OUT_ST_LSB] = ok_next ? ctlf_pkg::ST_OK
                                                      : ctlf_pkg::ST_REJECT;
        out_data_next[ctlf_pkg::OUT_PH_LSB +: PW]    = phase_next;
        out_data_next[ctlf_pkg::OUT_BUSY_LSB]        = ctlf_pkg::phase_active(phase_next);
        out_data_next[ctlf_pkg::OUT_EP_LSB +: TW]    = epoch_next;
        out_data_next[ctlf_pkg::OUT_E1_LSB +: EW]    = err1_next;
        out_data_next[ctlf_pkg::OUT_E2_LSB +: EW]    = err2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ctlf_pkg::PH_IDLE;
            epoch_reg     <= '0;
            err1_reg      <= '0;
            err2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                phase_reg <= phase_next;
                epoch_reg <= epoch_next;
                err1_reg  <= err1_next;
                err2_reg  <= err2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ctlf_checker.sv @@
// ctlf_checker: port-level checks on the result stream of the lifecycle controller.
// depends on ctlf_pkg; bound to capture_task_lifecycle_fsm_unit below.
`timescale 1ns / 1ps
`default_nettype none

module ctlf_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         m_axis_tvalid,
    input wire                         m_axis_tready,
    input wire [ctlf_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic [ctlf_pkg::PHASE_W-1:0] ph;
    logic                         busy;
    logic [ctlf_pkg::TIME_W-1:0]  ep;
    logic [ctlf_pkg::ERR_W-1:0]   e1;
    logic [ctlf_pkg::ERR_W-1:0]   e2;

    assign ph   = m_axis_tdata[ctlf_pkg::OUT_PH_LSB +: ctlf_pkg::PHASE_W];
    assign busy = m_axis_tdata[ctlf_pkg::OUT_BUSY_LSB];
    assign ep   = m_axis_tdata[ctlf_pkg::OUT_EP_LSB +: ctlf_pkg::TIME_W];
    assign e1   = m_axis_tdata[ctlf_pkg::OUT_E1_LSB +: ctlf_pkg::ERR_W];
    assign e2   = m_axis_tdata[ctlf_pkg::OUT_E2_LSB +: ctlf_pkg::ERR_W];

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed under stall");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> busy == (ph >= ctlf_pkg::PH_PREPARING &&
                                   ph <= ctlf_pkg::PH_COMMITTING))
        else $error("busy flag disagrees with phase");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ph <= ctlf_pkg::PH_FAILED)
        else $error("phase out of range");

    // preparing is reached only by begin, which clears the job record
    a_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ph == ctlf_pkg::PH_PREPARING |-> ep == '0 && e1 == '0 && e2 == '0)
        else $error("preparing job carries stale epoch or errors");

    a_slots: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && e2 != '0 |-> e1 != '0)
        else $error("secondary error set without primary");

endmodule

bind capture_task_lifecycle_fsm_unit ctlf_checker u_ctlf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/tb_capture_task_lifecycle_fsm_unit.sv @@
// tb_capture_task_lifecycle_fsm_unit: drives event words into the job phase tracker and
// checks every result word against a fixed expected word or a local model of the job state.
// depends on ctlf_pkg and capture_task_lifecycle_fsm_unit.
`timescale 1ns / 1ps

module tb_capture_task_lifecycle_fsm_unit;

    import ctlf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int ROUND_ITEMS = 234;

    typedef struct packed {
        kind_t              kind;
        logic               id_present;
        logic [TARGET_W-1:0] mask;
        logic [TIME_W-1:0]  deadline;
        logic [PHASE_W-1:0] exp_ph;
        logic [PHASE_W-1:0] nxt_ph;
        logic [TIME_W-1:0]  epoch;
        logic [ERR_W-1:0]   code;
    } ev_t;

    typedef struct packed {
        logic               status;
        logic [PHASE_W-1:0] phase;
        logic               busy;
        logic [TIME_W-1:0]  epoch;
        logic [ERR_W-1:0]   err_a;
        logic [ERR_W-1:0]   err_b;
    } res_t;

    typedef struct packed {
        ev_t  ev;
        logic typed;
        res_t res;
    } step_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    wire                  s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic [KIND_W-1:0]    s_axis_tuser = '0;
    wire                  m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    wire  [OUT_W-1:0]     m_axis_tdata;

    // model of the job
    phase_t               job_ph = PH_IDLE;
    logic [TARGET_W-1:0]  job_mask = '0;
    logic [TIME_W-1:0]    job_dl = '0;
    logic [TIME_W-1:0]    job_epoch = '0;
    logic [ERR_W-1:0]     fault_a = '0;
    logic [ERR_W-1:0]     fault_b = '0;

    res_t                 job_results_due[$];
    step_t                script[$];
    int                   mismatches = 0;
    int                   stall_cycles = 0;
    int                   src_idle_pct = 8;
    int                   dst_idle_pct = 64;

    capture_task_lifecycle_fsm_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic in_flight(input logic [PHASE_W-1:0] p);
        return (p >= PH_PREPARING) && (p <= PH_COMMITTING);
    endfunction

    function automatic logic move_ok(input phase_t from, input logic [PHASE_W-1:0] to);
        if (to == PH_FAILED)
        begin
            return in_flight(from);
        end
        case ({from, to})
            {PH_PREPARING, PH_READY},     {PH_PREPARING, PH_STOPPING},
            {PH_READY, PH_STARTING},      {PH_READY, PH_STOPPING},
            {PH_STARTING, PH_RUNNING},    {PH_STARTING, PH_STOPPING},
            {PH_RUNNING, PH_STOPPING},    {PH_STOPPING, PH_COMMITTING},
            {PH_COMMITTING, PH_DONE}:     return 1'b1;
            default:                      return 1'b0;
        endcase
    endfunction

    // applies one event to the job model and returns the result word it gives
    task automatic advance_job(input ev_t e, output res_t r);
        logic ok;
        logic [ERR_W-1:0] code;
        ok = 1'b0;
        case (e.kind)
            EV_BEGIN:
            begin
                if (e.id_present && ((e.mask & TARGET_KEEP) != '0) &&
                    (job_ph == PH_IDLE || job_ph == PH_DONE || job_ph == PH_FAILED))
                begin
                    job_ph    = PH_PREPARING;
                    job_mask  = e.mask & TARGET_KEEP;
                    job_dl    = e.deadline;
                    job_epoch = '0;
                    fault_a   = '0;
                    fault_b   = '0;
                    ok        = 1'b1;
                end
            end
            EV_MOVE:
            begin
                if (e.exp_ph == job_ph && e.nxt_ph <= PH_FAILED && move_ok(job_ph, e.nxt_ph))
                begin
                    job_ph = phase_t'(e.nxt_ph);
                    ok     = 1'b1;
                end
            end
            EV_STOP:
            begin
                if (e.epoch != '0)
                begin
                    // stopping and later: first epoch sticks, repeats must match it
                    if (job_ph >= PH_STOPPING)
                    begin
                        if (job_epoch == '0)
                        begin
                            job_epoch = e.epoch;
                        end
                        ok = (job_epoch == e.epoch);
                    end
                    else if (job_ph != PH_IDLE)
                    begin
                        job_ph    = PH_STOPPING;
                        job_epoch = e.epoch;
                        ok        = 1'b1;
                    end
                end
            end
            default:
            begin
                code = e.code & ERROR_KEEP;
                if (code != '0)
                begin
                    if (fault_a == '0)
                    begin
                        fault_a = code;
                    end
                    else if (fault_b == '0)
                    begin
                        fault_b = code;
                    end
                    if (in_flight(job_ph))
                    begin
                        job_ph = PH_FAILED;
                    end
                    ok = 1'b1;
                end
            end
        endcase
        r.status = ok ? ST_OK : ST_REJECT;
        r.phase  = job_ph;
        r.busy   = in_flight(job_ph);
        r.epoch  = job_epoch;
        r.err_a  = fault_a;
        r.err_b  = fault_b;
    endtask

    function automatic ev_t ev_of(input kind_t k, input logic id, input logic [31:0] m,
                                  input logic [63:0] dl, input logic [3:0] ex,
                                  input logic [3:0] nx, input logic [63:0] ep,
                                  input logic [7:0] code);
        ev_t e;
        e.kind       = k;
        e.id_present = id;
        e.mask       = m;
        e.deadline   = dl;
        e.exp_ph     = ex;
        e.nxt_ph     = nx;
        e.epoch      = ep;
        e.code       = code;
        return e;
    endfunction

    function automatic res_t res_of(input logic st, input logic [3:0] ph, input logic busy,
                                    input logic [63:0] ep, input logic [7:0] ea,
                                    input logic [7:0] eb);
        res_t r;
        r.status = st;
        r.phase  = ph;
        r.busy   = busy;
        r.epoch  = ep;
        r.err_a  = ea;
        r.err_b  = eb;
        return r;
    endfunction

    task automatic add_step(input ev_t e, input logic typed, input res_t r);
        step_t s;
        s.ev    = e;
        s.typed = typed;
        s.res   = r;
        script.push_back(s);
    endtask

    function automatic ev_t rand_event();
        return ev_of(kind_t'($urandom_range(3)), 1'($urandom_range(1)), $urandom,
                     {$urandom, $urandom}, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     {$urandom, $urandom}, 8'($urandom_range(255)));
    endfunction

    // mostly well-formed lifecycles with random payload, the rest noise
    function automatic ev_t next_job_event();
        ev_t e;
        int  pick;
        e    = rand_event();
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            if ($urandom_range(3) == 0)
            begin
                e.mask  = '0;
                e.epoch = '0;
                e.code  = '0;
            end
            if ($urandom_range(1) == 1)
            begin
                e.exp_ph = job_ph;
            end
        end
        else if (job_ph == PH_IDLE || job_ph == PH_DONE || job_ph == PH_FAILED)
        begin
            if (pick < 35)
            begin
                e.kind  = ($urandom_range(1) == 1) ? EV_STOP : EV_FAIL;
                e.epoch = (job_epoch != '0 && $urandom_range(1) == 1) ? job_epoch
                                                                    : 64'($urandom_range(3));
            end
            else
            begin
                e.kind       = EV_BEGIN;
                e.id_present = 1'b1;
                if (e.mask == '0)
                begin
                    e.mask = 32'h1;
                end
            end
        end
        else
        begin
            e.kind   = EV_MOVE;
            e.exp_ph = job_ph;
            if (pick < 75)
            begin
                case (job_ph)
                    PH_PREPARING:  e.nxt_ph = PH_READY;
                    PH_READY:      e.nxt_ph = PH_STARTING;
                    PH_STARTING:   e.nxt_ph = PH_RUNNING;
                    PH_RUNNING:    e.nxt_ph = PH_STOPPING;
                    PH_STOPPING:   e.nxt_ph = PH_COMMITTING;
                    default:       e.nxt_ph = PH_DONE;
                endcase
            end
            else if (pick < 82)
            begin
                e.nxt_ph = ($urandom_range(1) == 1) ? PH_FAILED : PH_STOPPING;
            end
            else if (pick < 93)
            begin
                e.kind = EV_STOP;
                if (job_epoch != '0 && $urandom_range(1) == 1)
                begin
                    e.epoch = job_epoch;
                end
                else if ($urandom_range(1) == 1)
                begin
                    e.epoch = 64'($urandom_range(1, 3));
                end
            end
            else
            begin
                e.kind = EV_FAIL;
            end
        end
        return e;
    endfunction

    task automatic send_event(input ev_t e, input logic typed, input res_t typed_res);
        res_t            r;
        logic [IN_W-1:0] word;
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
            begin
                @(posedge clk);
            end
        end
        word                          = '0;
        word[IN_ID_LSB]               = e.id_present;
        word[IN_MASK_LSB +: TARGET_W] = e.mask;
        word[IN_DL_LSB +: TIME_W]     = e.deadline;
        word[IN_EXP_LSB +: PHASE_W]   = e.exp_ph;
        word[IN_NXT_LSB +: PHASE_W]   = e.nxt_ph;
        word[IN_EP_LSB +: TIME_W]     = e.epoch;
        word[IN_ERR_LSB +: ERR_W]     = e.code;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= e.kind;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        advance_job(e, r);
        job_results_due.push_back(typed ? typed_res : r);
    endtask

    // hold the sender off until every pending result word is out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (job_results_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tdata[OUT_ST_LSB];
            got.phase  = m_axis_tdata[OUT_PH_LSB +: PHASE_W];
            got.busy   = m_axis_tdata[OUT_BUSY_LSB];
            got.epoch  = m_axis_tdata[OUT_EP_LSB +: TIME_W];
            got.err_a  = m_axis_tdata[OUT_E1_LSB +: ERR_W];
            got.err_b  = m_axis_tdata[OUT_E2_LSB +: ERR_W];
            if (job_results_due.size() == 0)
            begin
                $display("%0t: result word with no pending event, got %0h", $time,
                         m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = job_results_due.pop_front();
                compare_field("status", 64'(want.status), 64'(got.status));
                compare_field("phase", 64'(want.phase), 64'(got.phase));
                compare_field("busy_res", 64'(want.busy), 64'(got.busy));
                compare_field("stop_epoch_out", want.epoch, got.epoch);
                compare_field("first_error", 64'(want.err_a), 64'(got.err_a));
                compare_field("second_error", 64'(want.err_b), 64'(got.err_b));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        res_t none;
        none = '0;

        // rejects straight after reset, then one begin taken and a second begin rejected
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, PH_IDLE, PH_PREPARING, 64'h0, 8'h0),
                 1'b1, res_of(ST_REJECT, PH_IDLE, 1'b0, 64'h0, 8'h0, 8'h0));
        add_step(ev_of(EV_STOP, 1'b0, 32'h0, 64'h0, 4'h0, 4'h0, 64'h5, 8'h0),
                 1'b1, res_of(ST_REJECT, PH_IDLE, 1'b0, 64'h0, 8'h0, 8'h0));
        add_step(ev_of(EV_FAIL, 1'b1, '1, '1, 4'hf, 4'hf, '1, 8'h0),
                 1'b1, res_of(ST_REJECT, PH_IDLE, 1'b0, 64'h0, 8'h0, 8'h0));
        add_step(ev_of(EV_BEGIN, 1'b0, 32'hff, 64'h10, 4'h0, 4'h0, 64'h0, 8'h0),
                 1'b1, res_of(ST_REJECT, PH_IDLE, 1'b0, 64'h0, 8'h0, 8'h0));
        add_step(ev_of(EV_BEGIN, 1'b1, 32'h0, '1, 4'h0, 4'h0, 64'h0, 8'h0),
                 1'b1, res_of(ST_REJECT, PH_IDLE, 1'b0, 64'h0, 8'h0, 8'h0));
        add_step(ev_of(EV_BEGIN, 1'b1, '1, '1, 4'hf, 4'hf, '1, 8'hff),
                 1'b1, res_of(ST_OK, PH_PREPARING, 1'b1, 64'h0, 8'h0, 8'h0));
        add_step(ev_of(EV_BEGIN, 1'b1, 32'h1, 64'h0, 4'h0, 4'h0, 64'h0, 8'h0),
                 1'b1, res_of(ST_REJECT, PH_PREPARING, 1'b1, 64'h0, 8'h0, 8'h0));
        // phase codes above eight, then moves up to running and one illegal move back
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, 4'hf, PH_READY, 64'h0, 8'h0), 1'b0, none);
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, PH_PREPARING, 4'hf, 64'h0, 8'h0),
                 1'b0, none);
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, PH_PREPARING, PH_READY, 64'h0, 8'h0),
                 1'b0, none);
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, PH_READY, PH_STARTING, 64'h0, 8'h0),
                 1'b0, none);
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, PH_STARTING, PH_RUNNING, 64'h0, 8'h0),
                 1'b0, none);
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, PH_RUNNING, PH_STARTING, 64'h0, 8'h0),
                 1'b0, none);
        // stop epochs: zero, first, repeat, mismatch; then committing and done
        add_step(ev_of(EV_STOP, 1'b0, 32'h0, 64'h0, 4'h0, 4'h0, 64'h0, 8'h0), 1'b0, none);
        add_step(ev_of(EV_STOP, 1'b0, 32'h0, 64'h0, 4'h0, 4'h0, '1, 8'h0), 1'b0, none);
        add_step(ev_of(EV_STOP, 1'b0, 32'h0, 64'h0, 4'h0, 4'h0, '1, 8'h0), 1'b0, none);
        add_step(ev_of(EV_STOP, 1'b0, 32'h0, 64'h0, 4'h0, 4'h0, 64'h1, 8'h0), 1'b0, none);
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, PH_STOPPING, PH_COMMITTING, 64'h0, 8'h0),
                 1'b0, none);
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, PH_COMMITTING, PH_DONE, 64'h0, 8'h0),
                 1'b0, none);
        // error slots fill, third code dropped; then a new job moved to failed
        add_step(ev_of(EV_FAIL, 1'b0, 32'h0, 64'h0, 4'h0, 4'h0, 64'h0, 8'hff), 1'b0, none);
        add_step(ev_of(EV_FAIL, 1'b0, 32'h0, 64'h0, 4'h0, 4'h0, 64'h0, 8'h01), 1'b0, none);
        add_step(ev_of(EV_FAIL, 1'b0, 32'h0, 64'h0, 4'h0, 4'h0, 64'h0, 8'h02), 1'b0, none);
        add_step(ev_of(EV_BEGIN, 1'b1, 32'h8000_0000, 64'h0, 4'h0, 4'h0, 64'h0, 8'h0),
                 1'b0, none);
        add_step(ev_of(EV_MOVE, 1'b0, 32'h0, 64'h0, PH_PREPARING, PH_FAILED, 64'h0, 8'h0),
                 1'b0, none);
        // first stop epoch recorded after failure
        add_step(ev_of(EV_STOP, 1'b0, 32'h0, 64'h0, 4'h0, 4'h0, 64'h3, 8'h0), 1'b0, none);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            send_event(script[i].ev, script[i].typed, script[i].res);
        end
        drain_results();

        for (int round = 0; round < 3; round++)
        begin
            src_idle_pct = (round == 0) ? 8 : (round == 1) ? 64 : 0;
            dst_idle_pct = (round == 0) ? 64 : (round == 1) ? 8 : 0;
            repeat (ROUND_ITEMS)
            begin
                send_event(next_job_event(), 1'b0, none);
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && job_results_due.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ capture_task_lifecycle_fsm_unit.f @@
sv/ctlf_pkg.sv
sv/capture_task_lifecycle_fsm_unit.sv
sv/ctlf_checker.sv
tb/tb_capture_task_lifecycle_fsm_unit.sv
